// ===== rtl/bdth_pkg.sv =====
package bdth_pkg;

  localparam int FIELD_BITS = 4;   // raw level and LED word width
  localparam int TICK_W     = 32;
  localparam int CFG_W      = 16;
  localparam int HOLD_W     = 16;
  localparam int RST_IDX_W  = 2;
  localparam int REG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_LIMIT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_BUTTON   = 2'd2;

  // item kinds
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // per-button press mark
  localparam logic [1:0] MARK_NONE    = 2'd0;
  localparam logic [1:0] MARK_PRESSED = 2'd1;
  localparam logic [1:0] MARK_HOLD    = 2'd2;

  // per-button events for one scan
  typedef struct packed {
    logic toggle;     // new debounced press
    logic rel_reset;  // release of the reset-role button
    logic hold_inc;   // reset-role button still held, bump hold count
    logic fire;       // hold count reached the limit
  } lane_ev_t;

endpackage

// ===== rtl/bdth_lane.sv =====
module bdth_lane
  import bdth_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              lvl,
  input  logic [TICK_W-1:0] now_tick,
  input  logic [CFG_W-1:0]  debounce_ticks,
  input  logic              is_reset,
  input  logic              hold_fire,
  output lane_ev_t          ev
);

  logic              raw_r, raw_nxt;
  logic              deb_r, deb_nxt;
  logic [TICK_W-1:0] last_r, last_nxt;
  logic [1:0]        mark_r, mark_nxt;
  logic [TICK_W-1:0] elapsed;
  logic              pressed;

  always_comb begin
    raw_nxt  = lvl;
    last_nxt = (raw_r != lvl) ? now_tick : last_r;
    elapsed  = now_tick - last_nxt;
    deb_nxt  = deb_r;
    if ((raw_nxt != deb_r) && (elapsed > {{(TICK_W-CFG_W){1'b0}}, debounce_ticks})) begin
      deb_nxt = raw_nxt;
    end
    pressed  = !deb_nxt;

    mark_nxt = mark_r;
    ev       = '0;
    priority if (pressed && mark_r == MARK_NONE) begin
      ev.toggle = 1'b1;
      mark_nxt  = MARK_PRESSED;
    end else if (!pressed && mark_r != MARK_NONE) begin
      ev.rel_reset = is_reset;
      mark_nxt     = MARK_NONE;
    end else if (is_reset && pressed && mark_r == MARK_PRESSED) begin
      ev.hold_inc = 1'b1;
      if (hold_fire) begin
        ev.fire  = 1'b1;
        mark_nxt = MARK_HOLD;
      end
    end else begin
      // steady level, mark unchanged
      mark_nxt = mark_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= 1'b1;
      deb_r  <= 1'b1;
      last_r <= '0;
      mark_r <= MARK_NONE;
    end else if (step) begin
      raw_r  <= raw_nxt;
      deb_r  <= deb_nxt;
      last_r <= last_nxt;
      mark_r <= mark_nxt;
    end
  end

endmodule

// ===== rtl/button_debounce_toggle_hold_core.sv =====
// Button debounce / LED toggle / long-hold core.
//
// Input channel (in_valid / in_stall): one beat is a scan (in_cmd = 0) carrying
// active-low raw button levels and a free-running 32-bit tick stamp, or a set
// (in_cmd = 1) that overwrites the LED word with in_led_command.
// Result channel (out_valid / out_stall): exactly one beat per input beat, in
// order: the LED word after the item, a publish flag (some button toggled its
// LED on this scan) and an access-point request (reset-role button held for
// hold_limit scans).
// Config port: cfg_we / cfg_index / cfg_wdata write debounce_ticks (0),
// hold_limit (1) and reset_button_index (2); write only while the core is idle.
// Timing: the beat lands in an input register, all buttons are evaluated side
// by side from it and the result register loads from that evaluation;
// throughput is 1 beat per cycle while out_stall is low, set by the single
// state-update stage.
// out_stall holds the result register; the input register then fills and
// in_stall rises, so nothing is dropped. Reset (rst_n low, synchronous)
// releases all buttons, clears timers, marks, hold count and LED word, and
// restores the register defaults.
module button_debounce_toggle_hold_core
  import bdth_pkg::*;
#(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [FIELD_BITS-1:0] in_raw_levels,
  input  logic [TICK_W-1:0]     in_now_tick,
  input  logic [FIELD_BITS-1:0] in_led_command,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_BITS-1:0] out_led_state,
  output logic                  out_publish,
  output logic                  out_ap_mode_request,
  // config
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // config registers
  logic [CFG_W-1:0]     debounce_ticks_r;
  logic [HOLD_W-1:0]    hold_limit_r;
  logic [RST_IDX_W-1:0] rst_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= CFG_W'(50);
      hold_limit_r     <= HOLD_W'(1000);
      rst_idx_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_wdata;
        REG_HOLD_LIMIT:     hold_limit_r     <= cfg_wdata[HOLD_W-1:0];
        REG_RESET_BUTTON:   rst_idx_r        <= cfg_wdata[RST_IDX_W-1:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // input register stage
  logic                  s1_valid_r;
  logic                  s1_cmd_r;
  logic [FIELD_BITS-1:0] s1_raw_r;
  logic [TICK_W-1:0]     s1_now_r;
  logic [FIELD_BITS-1:0] s1_ledc_r;
  logic                  in_take;
  logic                  adv;
  logic                  step;

  logic                  out_valid_r;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign step     = adv && (s1_cmd_r == CMD_SCAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_cmd;
      s1_raw_r  <= in_raw_levels;
      s1_now_r  <= in_now_tick;
      s1_ledc_r <= in_led_command;
    end
  end

  // shared hold counter for the reset-role button
  logic [HOLD_W-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [HOLD_W-1:0] hold_inc_val;
  logic              hold_fire;

  assign hold_inc_val = hold_cnt_r + HOLD_W'(1);
  assign hold_fire    = (hold_inc_val >= hold_limit_r);

  // button lanes
  lane_ev_t [NUM_BUTTONS-1:0] ev;
  logic [NUM_BUTTONS-1:0]     tog_vec, rel_vec, inc_vec, fire_vec;
  logic [FIELD_BITS-1:0]      tog_mask;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic lvl;
    logic is_rst;

    if (g < FIELD_BITS) begin : g_pin
      assign lvl    = s1_raw_r[g];
      assign is_rst = (rst_idx_r == RST_IDX_W'(g));
    end else begin : g_nopin
      // no raw pin: reads released, never has the reset role
      assign lvl    = 1'b1;
      assign is_rst = 1'b0;
    end

    bdth_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .step          (step),
      .lvl           (lvl),
      .now_tick      (s1_now_r),
      .debounce_ticks(debounce_ticks_r),
      .is_reset      (is_rst),
      .hold_fire     (hold_fire),
      .ev            (ev[g])
    );

    assign tog_vec[g]  = ev[g].toggle;
    assign rel_vec[g]  = ev[g].rel_reset;
    assign inc_vec[g]  = ev[g].hold_inc;
    assign fire_vec[g] = ev[g].fire;
  end

  // only buttons with an LED bit toggle it
  for (genvar m = 0; m < FIELD_BITS; m++) begin : g_mask
    if (m < NUM_BUTTONS) begin : g_on
      assign tog_mask[m] = tog_vec[m];
    end else begin : g_off
      assign tog_mask[m] = 1'b0;
    end
  end

  always_comb begin
    hold_cnt_nxt = hold_cnt_r;
    priority if (|rel_vec) begin
      hold_cnt_nxt = '0;
    end else if (|fire_vec) begin
      hold_cnt_nxt = '0;
    end else if (|inc_vec) begin
      hold_cnt_nxt = hold_inc_val;
    end else begin
      // no hold activity this scan
      hold_cnt_nxt = hold_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt_r <= '0;
    end else if (step) begin
      hold_cnt_r <= hold_cnt_nxt;
    end
  end

  // LED word and result register
  logic [FIELD_BITS-1:0] led_r, led_nxt;
  logic [FIELD_BITS-1:0] out_led_r;
  logic                  out_pub_r;
  logic                  out_ap_r;

  assign led_nxt = (s1_cmd_r == CMD_SET) ? s1_ledc_r : (led_r ^ tog_mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        led_r       <= led_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_led_r <= led_nxt;
      out_pub_r <= step && (|tog_vec);
      out_ap_r  <= step && (|fire_vec);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_led_state       = out_led_r;
  assign out_publish         = out_pub_r;
  assign out_ap_mode_request = out_ap_r;

  // set beats never publish nor request
  a_set_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (s1_cmd_r == CMD_SET) |=> out_valid_r && !out_pub_r && !out_ap_r)
    else $error("set beat produced publish or request");

  // a fired request leaves the hold counter cleared
  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (|fire_vec) |=> hold_cnt_r == '0)
    else $error("hold count not cleared after request");

  // at most one lane may drive the hold counter
  a_one_holder: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(inc_vec) && $onehot0(rel_vec))
    else $error("several lanes drive the hold counter");

  // input side only stalls with a beat parked in the input register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled without a parked beat");

endmodule

// ===== tb/button_debounce_toggle_hold_core_tb.sv =====
`timescale 1ns / 1ps

module button_debounce_toggle_hold_core_tb
  import bdth_pkg::*;
;

  // Expected LED word and flags for one result beat
  typedef struct {
    logic [FIELD_BITS-1:0] led;
    logic                  publish;
    logic                  ap;
  } led_result_t;

  // Tracks the button bank the way the core should, one accepted beat at a time,
  // and checks result beats in order against what it worked out.
  class led_toggle_board;
    logic [CFG_W-1:0]      debounce;
    logic [HOLD_W-1:0]     hold_lim;
    logic [RST_IDX_W-1:0]  reset_idx;
    logic [FIELD_BITS-1:0] raw_q;
    logic [FIELD_BITS-1:0] deb_q;
    logic [TICK_W-1:0]     last_chg [FIELD_BITS];
    logic [1:0]            mark [FIELD_BITS];
    logic [HOLD_W-1:0]     hold_cnt;
    logic [FIELD_BITS-1:0] leds;
    led_result_t           pending_results [$];
    int                    errors;
    int                    n_checked;
    int                    n_publish;
    int                    n_ap;

    function new();
      debounce  = 16'd50;
      hold_lim  = 16'd1000;
      reset_idx = '0;
      raw_q     = '1;
      deb_q     = '1;
      for (int b = 0; b < FIELD_BITS; b++) begin
        last_chg[b] = '0;
        mark[b]     = MARK_NONE;
      end
      hold_cnt  = '0;
      leds      = '0;
      errors    = 0;
      n_checked = 0;
      n_publish = 0;
      n_ap      = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_DEBOUNCE_TICKS: debounce  = val;
        REG_HOLD_LIMIT:     hold_lim  = val;
        REG_RESET_BUTTON:   reset_idx = val[RST_IDX_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // Advance the button bank by one accepted beat and queue the result it causes.
    function void apply_beat(logic cmd, logic [FIELD_BITS-1:0] raw,
                             logic [TICK_W-1:0] now, logic [FIELD_BITS-1:0] ledc);
      led_result_t       res;
      logic              down;
      logic              is_rst;
      logic [TICK_W-1:0] elapsed;
      res.publish = 1'b0;
      res.ap      = 1'b0;
      if (cmd == CMD_SET) begin
        leds = ledc;
      end else begin
        for (int b = 0; b < FIELD_BITS; b++) begin
          is_rst = (b == reset_idx);
          // any raw edge restarts this button's stability timer
          if (raw_q[b] != raw[b]) begin
            raw_q[b]    = raw[b];
            last_chg[b] = now;
          end
          elapsed = now - last_chg[b];
          if (raw_q[b] != deb_q[b] && elapsed > {16'd0, debounce})
            deb_q[b] = raw_q[b];
          down = !deb_q[b];
          if (down && mark[b] == MARK_NONE) begin
            leds[b]     = ~leds[b];
            mark[b]     = MARK_PRESSED;
            res.publish = 1'b1;
          end else if (!down && mark[b] != MARK_NONE) begin
            mark[b] = MARK_NONE;
            if (is_rst)
              hold_cnt = '0;
          end else if (is_rst && down && mark[b] == MARK_PRESSED) begin
            hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt >= hold_lim) begin
              res.ap   = 1'b1;
              hold_cnt = '0;
              mark[b]  = MARK_HOLD;
            end
          end
        end
      end
      res.led = leds;
      pending_results.push_back(res);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10)
        $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [FIELD_BITS-1:0] led, logic pub, logic ap);
      led_result_t want;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected beat led %h publish %b ap %b", led, pub, ap));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (want.publish)
        n_publish++;
      if (want.ap)
        n_ap++;
      if (led !== want.led || pub !== want.publish || ap !== want.ap)
        note_error($sformatf("led %h/%h publish %b/%b ap %b/%b (expected/actual)",
                             want.led, led, want.publish, pub, want.ap, ap));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [FIELD_BITS-1:0] in_raw_levels;
  logic [TICK_W-1:0]     in_now_tick;
  logic [FIELD_BITS-1:0] in_led_command;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FIELD_BITS-1:0] out_led_state;
  logic                  out_publish;
  logic                  out_ap_mode_request;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  led_toggle_board board = new();

  // idle rates in percent, changed between phases
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // stimulus-side view of the tick clock and the current settings
  logic [TICK_W-1:0]     tick = 32'd10;
  int unsigned           cur_deb = 50;
  int unsigned           cur_idx = 0;
  logic [FIELD_BITS-1:0] gest_raw = '1;
  int                    gest_left = 0;

  int beats_sent = 0;
  int sets_sent = 0;
  int settings_used = 0;

  button_debounce_toggle_hold_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_raw_levels       (in_raw_levels),
    .in_now_tick         (in_now_tick),
    .in_led_command      (in_led_command),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_led_state       (out_led_state),
    .out_publish         (out_publish),
    .out_ap_mode_request (out_ap_mode_request),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Result side: random back-pressure, and every accepted beat is checked.
  // Values read here are the ones the core sampled at this same edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_led_state, out_publish, out_ap_mode_request);
  end

  // Present one beat, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_beat(input logic c, input logic [FIELD_BITS-1:0] r,
                           input logic [TICK_W-1:0] t, input logic [FIELD_BITS-1:0] l);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_cmd         <= c;
    in_raw_levels  <= r;
    in_now_tick    <= t;
    in_led_command <= l;
    do @(posedge clk); while (in_stall);
    board.apply_beat(c, r, t, l);
    beats_sent++;
  endtask

  // Scan beat dt ticks after the previous one; led_command is junk on scans.
  task automatic scan_dt(input logic [FIELD_BITS-1:0] r, input logic [TICK_W-1:0] dt);
    tick = tick + dt;
    send_beat(CMD_SCAN, r, tick, FIELD_BITS'($urandom_range(0, 15)));
  endtask

  // LED-word overwrite; raw levels and tick are don't-care and randomized.
  task automatic set_word(input logic [FIELD_BITS-1:0] v);
    send_beat(CMD_SET, FIELD_BITS'($urandom_range(0, 15)), $urandom, v);
    sets_sent++;
  endtask

  // Let the pipe drain before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_count() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers back to back, we held high across the burst.
  task automatic load_settings(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                               input logic [RST_IDX_W-1:0] idx);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE_TICKS;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= REG_HOLD_LIMIT;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_index <= REG_RESET_BUTTON;
    cfg_wdata <= CFG_W'(idx);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(REG_DEBOUNCE_TICKS, deb);
    board.set_reg(REG_HOLD_LIMIT, hold);
    board.set_reg(REG_RESET_BUTTON, CFG_W'(idx));
    cur_deb = deb;
    cur_idx = idx;
    settings_used++;
  endtask

  // Tick step: mostly long enough to settle the debouncer, sometimes too short,
  // now and then a jump anywhere in the 32-bit space.
  function automatic logic [TICK_W-1:0] pick_dt();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(0, cur_deb);
      9:       return $urandom;
      default: return cur_deb + $urandom_range(1, 4);
    endcase
  endfunction

  // Random traffic: mostly held button patterns (clean presses, long holds of
  // the reset-role button, releases), plus raw noise and LED-word sets.
  task automatic run_random(input int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        set_word(FIELD_BITS'($urandom_range(0, 15)));
      end else if (roll < 20) begin
        scan_dt(FIELD_BITS'($urandom_range(0, 15)), pick_dt());
      end else begin
        if (gest_left == 0) begin
          case ($urandom_range(0, 5))
            0:       gest_raw = '1;
            1, 2:    gest_raw = 4'hF ^ (4'b0001 << cur_idx);
            default: gest_raw = FIELD_BITS'($urandom_range(0, 15));
          endcase
          gest_left = $urandom_range(2, 12);
        end
        gest_left--;
        scan_dt(gest_raw, pick_dt());
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                           input logic [RST_IDX_W-1:0] idx, input int n);
    drain();
    load_settings(deb, hold, idx);
    run_random(n);
  endtask

  // Directed opening: set extremes, a clean press/hold/release of the reset-role
  // button, all buttons at once across the tick wrap, a bounce that restarts
  // timers, and a set while buttons are held.
  task automatic run_directed();
    drain();
    load_settings(16'd2, 16'd2, 2'd0);
    set_word(4'hF);
    set_word(4'h0);
    scan_dt(4'hF, 1);
    scan_dt(4'hE, 1);      // button 0 goes down, timer restarts
    scan_dt(4'hE, 3);      // stable long enough: toggle + publish
    scan_dt(4'hE, 1);      // held, count 1
    scan_dt(4'hE, 1);      // count reaches limit: access-point request
    scan_dt(4'hE, 1);      // hold mark, nothing more
    scan_dt(4'hF, 1);
    scan_dt(4'hF, 3);      // debounced release clears mark
    tick = 32'hFFFF_FFFE;
    scan_dt(4'h0, 1);      // all down right at the wrap
    scan_dt(4'h0, 3);      // elapsed spans the wrap: all toggle
    scan_dt(4'h5, 1);      // glitch on buttons 0 and 2
    scan_dt(4'h0, 1);      // bounce back before it settles
    scan_dt(4'h0, 5);
    set_word(4'hA);        // overwrite while held
    scan_dt(4'hF, 1);
    scan_dt(4'hF, 5);      // release everything
    scan_dt(4'hF, 0);      // zero-step scan
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_cmd         <= CMD_SCAN;
    in_raw_levels  <= '1;
    in_now_tick    <= '0;
    in_led_command <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_DEBOUNCE_TICKS;
    cfg_wdata      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles 30%, receiver stalls 59%
    send_idle_pct  = 30;
    recv_stall_pct = 59;
    run_directed();
    run_phase(16'd0, 16'd1, 2'd1, 125);
    run_phase(16'd7, 16'd4, 2'd3, 125);

    // the other way round
    send_idle_pct  = 59;
    recv_stall_pct = 30;
    run_phase(16'd65535, 16'd65535, 2'd2, 125);
    run_phase(16'd3, 16'd0, 2'd0, 125);   // limit of zero fires on first held scan

    // full rate, no idling either side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(16'd12, 16'd2, 2'd2, 125);
    run_phase(16'd1, 16'd6, 2'd1, 125);

    in_valid <= 1'b0;
    while (board.pending_count() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d beats (%0d LED sets) over %0d register settings, %0d results checked",
             beats_sent, sets_sent, settings_used, board.n_checked);
    $display("%0d publish beats, %0d access-point requests, %0d mismatches",
             board.n_publish, board.n_ap, board.errors);
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", board.pending_count());
    $display("status: fail");
    $finish;
  end

endmodule
